[src/status_led_pattern_generator_core_defines.svh]
// Assertion macros used by the status LED pattern generator checker.
`ifndef STATUS_LED_PATTERN_GENERATOR_CORE_DEFINES_SVH
`define STATUS_LED_PATTERN_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside of reset.
`define SLPG_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slpg same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside of reset.
`define SLPG_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slpg next-cycle check failed");

`endif

[src/slpg_pkg.sv]
// Types, constants and helper functions of the status LED pattern generator.
package slpg_pkg;

    localparam int NUM_LEDS   = 3;
    localparam int TIMER_BITS = 16;
    localparam int IDX_W      = $clog2(NUM_LEDS);
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_FLASH = 2'd2,
        OP_BEGIN = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PAT_OFF   = 2'd0,
        PAT_BLINK = 2'd1,
        PAT_CHASE = 2'd2
    } pattern_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_ACTIVE_LOW  = 3'd1,
        CFG_BLINK_MS    = 3'd2,
        CFG_CHASE_MS    = 3'd3,
        CFG_FLASH_MS    = 3'd4,
        CFG_SELFTEST_MS = 3'd5
    } cfg_index_t;

    localparam logic [MS_W-1:0] BLINK_MS_RST    = MS_W'(500);
    localparam logic [MS_W-1:0] CHASE_MS_RST    = MS_W'(150);
    localparam logic [MS_W-1:0] FLASH_MS_RST    = MS_W'(300);
    localparam logic [MS_W-1:0] SELFTEST_MS_RST = MS_W'(200);

    typedef struct packed {
        logic            enable;
        logic            active_low;
        logic [MS_W-1:0] blink_ms;
        logic [MS_W-1:0] chase_ms;
        logic [MS_W-1:0] flash_ms;
        logic [MS_W-1:0] selftest_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] pattern;
        logic [1:0] color;
    } item_t;

    typedef struct packed {
        logic [NUM_LEDS-1:0] led_levels;
        logic                self_testing;
    } result_t;

    // One-hot LED mask for an index; indexes past the last LED light nothing.
    function automatic logic [NUM_LEDS-1:0] one_led(input logic [3:0] idx);
        logic [NUM_LEDS-1:0] mask;
        mask = '0;
        if (int'(idx) < NUM_LEDS)
        begin
            mask = NUM_LEDS'(1) << idx;
        end
        return mask;
    endfunction

endpackage

[src/status_led_pattern_generator_core.sv]
// Top level of the status LED pattern generator: configuration registers and stages.
//
// This block drives NUM_LEDS status LEDs (bit 0 red, bit 1 yellow, bit 2 green) from a
// stream of events: a one-millisecond tick, a pattern select (off, all-LED blink, one-hot
// chase), a colour flash that overrides the pattern until its flash_ms-th tick, and a
// self-test that lights each LED in turn for selftest_ms ticks and then selects the off
// pattern. Each enabled tick yields exactly one result transfer with the pin levels after
// the configured polarity and the self-test flag; every other event yields none. The
// block takes one event per clock cycle while in_stall is low. An accepted event is
// held in the input register while its state update and LED choice are computed, and
// an enabled tick's result is then registered in the output register until taken.
// in_stall rises only while the output register holds a result that the downstream
// side is stalling and the input register already holds an event that would produce
// another. Configuration writes are always taken (cfg_ready stays high) and are meant
// to be issued only while no event is in flight; writes beyond the last register index
// are ignored. There is no start-up clearing pass: after reset the block is ready.
module status_led_pattern_generator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // Event channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          op,
    input  logic [1:0]                          pattern,
    input  logic [1:0]                          color,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [slpg_pkg::NUM_LEDS-1:0]       led_levels,
    output logic                                self_testing,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [slpg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slpg_pkg::MS_W-1:0]           cfg_data
);

    slpg_pkg::cfg_t    cfg_reg;
    slpg_pkg::cfg_t    cfg_next;
    slpg_pkg::item_t   in_item;
    slpg_pkg::item_t   item;
    slpg_pkg::result_t res;
    slpg_pkg::result_t out_res;
    logic              item_valid;
    logic              take;
    logic              res_valid;
    logic              out_free;

    // The configuration port never pushes back.
    assign cfg_ready = 1'b1;

    // Register write decode; unknown indexes leave every register unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                slpg_pkg::CFG_ENABLE:      cfg_next.enable      = cfg_data[0];
                slpg_pkg::CFG_ACTIVE_LOW:  cfg_next.active_low  = cfg_data[0];
                slpg_pkg::CFG_BLINK_MS:    cfg_next.blink_ms    = cfg_data;
                slpg_pkg::CFG_CHASE_MS:    cfg_next.chase_ms    = cfg_data;
                slpg_pkg::CFG_FLASH_MS:    cfg_next.flash_ms    = cfg_data;
                slpg_pkg::CFG_SELFTEST_MS: cfg_next.selftest_ms = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= 1'b1;
            cfg_reg.active_low  <= 1'b0;
            cfg_reg.blink_ms    <= slpg_pkg::BLINK_MS_RST;
            cfg_reg.chase_ms    <= slpg_pkg::CHASE_MS_RST;
            cfg_reg.flash_ms    <= slpg_pkg::FLASH_MS_RST;
            cfg_reg.selftest_ms <= slpg_pkg::SELFTEST_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_item.op      = op;
    assign in_item.pattern = pattern;
    assign in_item.color   = color;

    slpg_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // All per-event work happens here, between the two register stages.
    slpg_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    slpg_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign led_levels   = out_res.led_levels;
    assign self_testing = out_res.self_testing;

endmodule

[src/slpg_in_stage.sv]
// Input register stage: holds one accepted item until the engine takes it.
module slpg_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  slpg_pkg::item_t in_item,
    input  logic            take,
    output logic            item_valid,
    output slpg_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    slpg_pkg::item_t item_reg;
    logic            load;

    // The stage refills in the same cycle that the engine takes its item.
    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/slpg_engine.sv]
// Pattern engine: phase counters, flash and self-test state, and LED selection.
module slpg_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  slpg_pkg::cfg_t    cfg,
    input  logic              item_valid,
    input  slpg_pkg::item_t   item,
    input  logic              out_free,
    output logic              take,
    output logic              res_valid,
    output slpg_pkg::result_t res
);

    slpg_pkg::pattern_t                 pattern_sel_reg, pattern_sel_next;
    logic [slpg_pkg::TIMER_BITS-1:0]    blink_count_reg, blink_count_next;
    logic                               blink_lit_reg, blink_lit_next;
    logic [slpg_pkg::TIMER_BITS-1:0]    chase_count_reg, chase_count_next;
    logic [slpg_pkg::IDX_W-1:0]         chase_index_reg, chase_index_next;
    logic                               flash_active_reg, flash_active_next;
    logic [1:0]                         flash_hue_reg, flash_hue_next;
    logic [slpg_pkg::TIMER_BITS-1:0]    flash_count_reg, flash_count_next;
    logic                               test_active_reg, test_active_next;
    logic [slpg_pkg::IDX_W-1:0]         test_index_reg, test_index_next;
    logic [slpg_pkg::TIMER_BITS-1:0]    test_count_reg, test_count_next;

    logic makes_result;

    // Only an enabled tick produces a result; everything else always proceeds.
    assign makes_result = cfg.enable && (item.op == slpg_pkg::OP_TICK);
    assign take         = item_valid && (!makes_result || out_free);

    always_comb
    begin
        logic [slpg_pkg::TIMER_BITS-1:0] blink_inc;
        logic [slpg_pkg::TIMER_BITS-1:0] chase_inc;
        logic [slpg_pkg::TIMER_BITS-1:0] test_inc;
        logic [slpg_pkg::TIMER_BITS-1:0] flash_inc;
        logic [slpg_pkg::NUM_LEDS-1:0]   lit;

        pattern_sel_next  = pattern_sel_reg;
        blink_count_next  = blink_count_reg;
        blink_lit_next    = blink_lit_reg;
        chase_count_next  = chase_count_reg;
        chase_index_next  = chase_index_reg;
        flash_active_next = flash_active_reg;
        flash_hue_next    = flash_hue_reg;
        flash_count_next  = flash_count_reg;
        test_active_next  = test_active_reg;
        test_index_next   = test_index_reg;
        test_count_next   = test_count_reg;
        blink_inc         = blink_count_reg + 1'b1;
        chase_inc         = chase_count_reg + 1'b1;
        test_inc          = test_count_reg + 1'b1;
        flash_inc         = flash_count_reg + 1'b1;
        lit               = '0;
        res_valid         = 1'b0;

        if (take && cfg.enable)
        begin
            case (item.op)
                slpg_pkg::OP_SET:
                begin
                    if (!test_active_reg
                        && (item.pattern == slpg_pkg::PAT_OFF
                            || item.pattern == slpg_pkg::PAT_BLINK
                            || item.pattern == slpg_pkg::PAT_CHASE)
                        && item.pattern != pattern_sel_reg)
                    begin
                        pattern_sel_next = slpg_pkg::pattern_t'(item.pattern);
                        blink_count_next = '0;
                        blink_lit_next   = 1'b1;
                        chase_count_next = '0;
                        chase_index_next = '0;
                    end
                end
                slpg_pkg::OP_FLASH:
                begin
                    if (!test_active_reg)
                    begin
                        flash_active_next = 1'b1;
                        flash_hue_next    = item.color;
                        flash_count_next  = '0;
                    end
                end
                slpg_pkg::OP_BEGIN:
                begin
                    test_active_next = 1'b1;
                    test_index_next  = '0;
                    test_count_next  = '0;
                end
                default:
                begin
                    // Tick: advance every running counter by one millisecond.
                    if (32'(blink_inc) >= 32'(cfg.blink_ms))
                    begin
                        blink_count_next = '0;
                        blink_lit_next   = !blink_lit_reg;
                    end
                    else
                    begin
                        blink_count_next = blink_inc;
                    end

                    if (32'(chase_inc) >= 32'(cfg.chase_ms))
                    begin
                        chase_count_next = '0;
                        if (32'(chase_index_reg) + 32'd1 >= 32'(slpg_pkg::NUM_LEDS))
                        begin
                            chase_index_next = '0;
                        end
                        else
                        begin
                            chase_index_next = chase_index_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        chase_count_next = chase_inc;
                    end

                    if (test_active_reg)
                    begin
                        if (32'(test_inc) >= 32'(cfg.selftest_ms))
                        begin
                            test_count_next = '0;
                            if (32'(test_index_reg) + 32'd1 >= 32'(slpg_pkg::NUM_LEDS))
                            begin
                                // Self-test done: back to the off pattern, fresh phase.
                                test_active_next  = 1'b0;
                                test_index_next   = '0;
                                pattern_sel_next  = slpg_pkg::PAT_OFF;
                                blink_count_next  = '0;
                                blink_lit_next    = 1'b1;
                                chase_count_next  = '0;
                                chase_index_next  = '0;
                                flash_active_next = 1'b0;
                                flash_count_next  = '0;
                            end
                            else
                            begin
                                test_index_next = test_index_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            test_count_next = test_inc;
                        end
                    end

                    if (test_active_next)
                    begin
                        lit = slpg_pkg::one_led(4'(test_index_next));
                    end
                    else
                    begin
                        if (flash_active_next)
                        begin
                            if (32'(flash_inc) < 32'(cfg.flash_ms))
                            begin
                                lit              = slpg_pkg::one_led(4'(flash_hue_reg));
                                flash_count_next = flash_inc;
                            end
                            else
                            begin
                                flash_active_next = 1'b0;
                                flash_count_next  = '0;
                            end
                        end
                        if (!flash_active_next)
                        begin
                            case (pattern_sel_next)
                                slpg_pkg::PAT_BLINK:
                                    lit = blink_lit_next ? '1 : '0;
                                slpg_pkg::PAT_CHASE:
                                    lit = slpg_pkg::one_led(4'(chase_index_next));
                                default:
                                    lit = '0;
                            endcase
                        end
                    end
                    res_valid = 1'b1;
                end
            endcase
        end

        res.led_levels   = lit ^ {slpg_pkg::NUM_LEDS{cfg.active_low}};
        res.self_testing = test_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_sel_reg  <= slpg_pkg::PAT_OFF;
            blink_count_reg  <= '0;
            blink_lit_reg    <= 1'b1;
            chase_count_reg  <= '0;
            chase_index_reg  <= '0;
            flash_active_reg <= 1'b0;
            flash_hue_reg    <= '0;
            flash_count_reg  <= '0;
            test_active_reg  <= 1'b0;
            test_index_reg   <= '0;
            test_count_reg   <= '0;
        end
        else
        begin
            pattern_sel_reg  <= pattern_sel_next;
            blink_count_reg  <= blink_count_next;
            blink_lit_reg    <= blink_lit_next;
            chase_count_reg  <= chase_count_next;
            chase_index_reg  <= chase_index_next;
            flash_active_reg <= flash_active_next;
            flash_hue_reg    <= flash_hue_next;
            flash_count_reg  <= flash_count_next;
            test_active_reg  <= test_active_next;
            test_index_reg   <= test_index_next;
            test_count_reg   <= test_count_next;
        end
    end

endmodule

[src/slpg_out_stage.sv]
// Output register stage: holds one result until the downstream side takes it.
module slpg_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  slpg_pkg::result_t res,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_stall,
    output slpg_pkg::result_t out_res
);

    logic              valid_reg;
    logic              valid_next;
    slpg_pkg::result_t res_reg;

    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = res_valid ? 1'b1 : (out_free ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[src/slpg_checker.sv]
// Port-level checker for the status LED pattern generator, bound to the top level.
`include "status_led_pattern_generator_core_defines.svh"

module slpg_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [slpg_pkg::NUM_LEDS-1:0] led_levels,
    input logic                          self_testing
);

    // A stalled result stays on the port unchanged.
    `SLPG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(led_levels) && $stable(self_testing))

    // During self-test exactly one LED is lit, whatever the pin polarity.
    `SLPG_ASSERT_IMP(a_test_one_led, clk, rst_n, out_valid && self_testing, $onehot(led_levels) || $onehot(~led_levels))

    // The input side only pushes back while the output side is blocked.
    `SLPG_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // An event that is pushed back is still offered in the next cycle.
    `SLPG_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid)

endmodule

bind status_led_pattern_generator_core slpg_checker u_slpg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .led_levels   (led_levels),
    .self_testing (self_testing)
);
